// File: sv/mbd_pkg.sv
// ============================================================================
// mbd_pkg
// Shared types and constants of the multi-button debouncer.
// ============================================================================
`default_nettype none

package mbd_pkg;

    localparam int BUTTON_W  = 4;
    localparam int TIME_W    = 32;
    localparam int NUMBTN_W  = 5;
    localparam int MASK_W    = 16;
    localparam int DEBOUNCE_W = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd5;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_CHANGE  = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        REG_NUM_BUTTONS = 3'd0,
        REG_DEBOUNCE_MS = 3'd1,
        REG_EDGE_MODE   = 3'd2,
        REG_PRESS_EN    = 3'd3,
        REG_RELEASE_EN  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [NUMBTN_W-1:0]   num_buttons;
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [MASK_W-1:0]     edge_mode;
        logic [MASK_W-1:0]     press_en;
        logic [MASK_W-1:0]     release_en;
    } t_cfg;

    typedef struct packed {
        logic [BUTTON_W-1:0] button;
        logic                level;
        logic [TIME_W-1:0]   now_ms;
    } t_sample;

    typedef struct packed {
        logic                fire;
        logic [BUTTON_W-1:0] button_id;
        t_event              ev;
        logic                level;
    } t_result;

endpackage

`default_nettype wire

// File: sv/mbd_if.sv
// ============================================================================
// mbd_sample_if / mbd_event_if
// Valid/ready channels for raw samples in and debounced events out.
// ============================================================================
`default_nettype none

interface mbd_sample_if;
    import mbd_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] button;
    logic                level;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output button, output level, output now_ms, input ready);
    modport sink   (input valid, input button, input level, input now_ms, output ready);
endinterface

interface mbd_event_if;
    import mbd_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] button_id;
    logic [1:0]          event_res;
    logic                stable_out;

    modport source (output valid, output button_id, output event_res, output stable_out,
                    input ready);
    modport sink   (input valid, input button_id, input event_res, input stable_out,
                    output ready);
endinterface

`default_nettype wire

// File: sv/mbd_cfg_regs.sv
// ============================================================================
// mbd_cfg_regs
// APB register file holding the debouncer configuration.
// ============================================================================
`default_nettype none

module mbd_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
    output logic [mbd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mbd_pkg::t_cfg               o_cfg
);
    import mbd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_buttons <= '0;
            r_cfg.debounce_ms <= DEBOUNCE_RST;
            r_cfg.edge_mode   <= '0;
            r_cfg.press_en    <= '0;
            r_cfg.release_en  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUM_BUTTONS: r_cfg.num_buttons <= pwdata[NUMBTN_W-1:0];
                REG_DEBOUNCE_MS: r_cfg.debounce_ms <= pwdata[DEBOUNCE_W-1:0];
                REG_EDGE_MODE:   r_cfg.edge_mode   <= pwdata[MASK_W-1:0];
                REG_PRESS_EN:    r_cfg.press_en    <= pwdata[MASK_W-1:0];
                REG_RELEASE_EN:  r_cfg.release_en  <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NUM_BUTTONS: prdata = DATA_W'(r_cfg.num_buttons);
            REG_DEBOUNCE_MS: prdata = DATA_W'(r_cfg.debounce_ms);
            REG_EDGE_MODE:   prdata = DATA_W'(r_cfg.edge_mode);
            REG_PRESS_EN:    prdata = DATA_W'(r_cfg.press_en);
            REG_RELEASE_EN:  prdata = DATA_W'(r_cfg.release_en);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/mbd_btn_state.sv
// ============================================================================
// mbd_btn_state
// Per-button raw, debounced and change-time state with the update logic.
// ============================================================================
`default_nettype none

module mbd_btn_state #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbd_pkg::t_cfg    i_cfg,
    input  mbd_pkg::t_sample i_item,
    input  logic             i_update,
    output mbd_pkg::t_result o_result
);
    import mbd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [NUMBTN_W-1:0] DEPTH_N = NUMBTN_W'(DEPTH);

    logic [DEPTH-1:0]  r_last_raw;
    logic [DEPTH-1:0]  r_debounced;
    logic [TIME_W-1:0] r_change_time [DEPTH];

    logic [IDX_W-1:0]  idx;
    logic              in_use;
    logic              raw_moved;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] held_for;
    logic              changed;
    logic              enabled;
    t_event            ev;

    assign idx    = i_item.button[IDX_W-1:0];
    assign in_use = ({1'b0, i_item.button} < i_cfg.num_buttons)
                 && ({1'b0, i_item.button} < DEPTH_N);

    always_comb begin
        raw_moved  = i_item.level != r_last_raw[idx];
        start_time = raw_moved ? i_item.now_ms : r_change_time[idx];
        // Wrapping difference: a timestamp that runs backwards counts as held.
        held_for   = i_item.now_ms - start_time;
        changed    = in_use && (held_for >= TIME_W'(i_cfg.debounce_ms))
                  && (i_item.level != r_debounced[idx]);

        if (i_cfg.edge_mode[i_item.button]) begin
            if (!i_item.level) begin
                ev      = EV_PRESS;
                enabled = i_cfg.press_en[i_item.button];
            end else begin
                ev      = EV_RELEASE;
                enabled = i_cfg.release_en[i_item.button];
            end
        end else begin
            ev      = EV_CHANGE;
            enabled = i_cfg.press_en[i_item.button];
        end

        o_result.fire      = changed && enabled;
        o_result.button_id = i_item.button;
        o_result.ev        = ev;
        o_result.level     = i_item.level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= '1;
            r_debounced <= '1;
            for (int i = 0; i < DEPTH; i++) begin
                r_change_time[i] <= '0;
            end
        end else if (i_update && in_use) begin
            r_last_raw[idx] <= i_item.level;
            if (raw_moved) begin
                r_change_time[idx] <= i_item.now_ms;
            end
            if (changed) begin
                r_debounced[idx] <= i_item.level;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/multi_button_debouncer_core.sv
// ============================================================================
// multi_button_debouncer_core
// Debounces time-stamped raw samples of up to sixteen buttons into events.
// ============================================================================
// Path: an accepted sample is held in the sample register, and its result, if
//   it fires, moves into the event register, from which it is presented.
// Throughput: one sample per cycle while the event output is not stalled; the
//   single read-modify-write of the per-button state between the sample
//   register and the event register sets that figure.
// Reset (synchronous, active low): all buttons read released, change times
//   are zero, both pipeline registers are empty and registers take defaults.
`default_nettype none

module multi_button_debouncer_core #(
    parameter int BUTTONS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mbd_sample_if.sink                  i_sample,
    mbd_event_if.source                 o_event,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
    output logic [mbd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import mbd_pkg::*;

    // Only the first sixteen buttons are addressable by the 4-bit index, so
    // state beyond that would never be touched.
    localparam int DEPTH = (BUTTONS < 16) ? BUTTONS : 16;

    t_cfg    cfg;
    t_result result;

    // Sample register (stage one) and event register (stage two).
    logic    r_in_valid, n_in_valid;
    t_sample r_in;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    logic    advance;
    logic    in_take;

    mbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The state is read and written in the same cycle for the item held in
    // the sample register, so consecutive samples of one button see each
    // other's updates without any forwarding.
    mbd_btn_state #(
        .DEPTH (DEPTH)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .i_update (advance),
        .o_result (result)
    );

    // The held sample moves on whenever the event register is free or is
    // being emptied this cycle, whether or not it produces an event.
    assign advance        = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_take        = i_sample.valid && i_sample.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_sample.ready) begin
            n_in_valid = i_sample.valid;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = result.fire;
        end else if (o_event.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.button <= i_sample.button;
            r_in.level  <= i_sample.level;
            r_in.now_ms <= i_sample.now_ms;
        end
        if (advance && result.fire) begin
            r_out <= result;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.button_id  = r_out.button_id;
    assign o_event.event_res  = r_out.ev;
    assign o_event.stable_out = r_out.level;

endmodule

`default_nettype wire

// File: sv/mbd_checker.sv
// ============================================================================
// mbd_checker
// Port-level checks on the debouncer event output, bound to the top level.
// ============================================================================
`default_nettype none

module mbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_button_id,
    input logic [1:0] i_event_res,
    input logic       i_stable_out
);
    import mbd_pkg::*;

    // Reset empties the event register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event valid after reset");

    // A stalled event stays presented unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_button_id)
            && $stable(i_event_res) && $stable(i_stable_out))
        else $error("stalled event changed");

    // A press always reports the pressed level.
    a_press_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_res == EV_PRESS) |-> !i_stable_out)
        else $error("press event with released level");

    // A release always reports the released level.
    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_res == EV_RELEASE) |-> i_stable_out)
        else $error("release event with pressed level");

    // No event code beyond the three defined ones.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_res == EV_PRESS) || (i_event_res == EV_RELEASE)
            || (i_event_res == EV_CHANGE))
        else $error("undefined event code");

endmodule

bind multi_button_debouncer_core mbd_checker u_mbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_event.valid),
    .i_out_ready  (o_event.ready),
    .i_button_id  (o_event.button_id),
    .i_event_res  (o_event.event_res),
    .i_stable_out (o_event.stable_out)
);

`default_nettype wire

// File: tb/multi_button_debouncer_core_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_button_debouncer_core_checker
// Watches the sample, event and register ports of the debouncer, keeps its
// own copy of the per-button state and the registers, and compares every
// event item that leaves the block with the oldest predicted one.
// ============================================================================
module multi_button_debouncer_core_checker
    import mbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_smp_valid,
    input  logic                  i_smp_ready,
    input  logic [BUTTON_W-1:0]   i_smp_button,
    input  logic                  i_smp_level,
    input  logic [TIME_W-1:0]     i_smp_now_ms,
    input  logic                  i_evt_valid,
    input  logic                  i_evt_ready,
    input  logic [BUTTON_W-1:0]   i_evt_button_id,
    input  logic [1:0]            i_evt_event_res,
    input  logic                  i_evt_stable_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Every 4-bit index fits the sixteen buttons, so only num_buttons gates.
    localparam int NBTN      = 16;
    localparam int PRINT_MAX = 20;

    typedef struct packed {
        logic [BUTTON_W-1:0] button;
        t_event              ev;
        logic                level;
    } t_btn_event;

    t_btn_event            due_events[$];
    logic                  raw_seen    [NBTN];
    logic                  stable_seen [NBTN];
    logic [TIME_W-1:0]     raw_since   [NBTN];
    logic [NUMBTN_W-1:0]   cfg_buttons;
    logic [DEBOUNCE_W-1:0] cfg_hold;
    logic [MASK_W-1:0]     cfg_edge;
    logic [MASK_W-1:0]     cfg_press;
    logic [MASK_W-1:0]     cfg_release;

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= PRINT_MAX) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Returns 1 when the sample yields an event item, which is then in ev.
    function automatic bit debounce_sample(input logic [BUTTON_W-1:0] b,
                                           input logic lvl,
                                           input logic [TIME_W-1:0] now,
                                           output t_btn_event ev);
        logic [TIME_W-1:0] held;
        ev = '0;
        if ({1'b0, b} >= cfg_buttons) begin
            return 1'b0;
        end
        if (lvl != raw_seen[b]) begin
            raw_since[b] = now;
            raw_seen[b]  = lvl;
        end
        // Wrapping difference: time running backwards looks like a long hold.
        held = now - raw_since[b];
        if (held < TIME_W'(cfg_hold) || lvl == stable_seen[b]) begin
            return 1'b0;
        end
        stable_seen[b] = lvl;
        ev.button = b;
        ev.level  = lvl;
        if (cfg_edge[b]) begin
            ev.ev = lvl ? EV_RELEASE : EV_PRESS;
            return lvl ? cfg_release[b] : cfg_press[b];
        end
        ev.ev = EV_CHANGE;
        return cfg_press[b];
    endfunction

    task automatic compare_event();
        t_btn_event want;
        if (due_events.size() == 0) begin
            report_mismatch($sformatf("event for button %0d with nothing expected",
                                      i_evt_button_id));
            return;
        end
        want = due_events.pop_front();
        if (i_evt_button_id !== want.button) begin
            report_mismatch($sformatf("button_id %0d, expected %0d",
                                      i_evt_button_id, want.button));
        end
        if (i_evt_event_res !== want.ev) begin
            report_mismatch($sformatf("event_res %0d, expected %s on button %0d",
                                      i_evt_event_res, want.ev.name(), want.button));
        end
        if (i_evt_stable_out !== want.level) begin
            report_mismatch($sformatf("stable_out %0b, expected %0b on button %0d",
                                      i_evt_stable_out, want.level, want.button));
        end
    endtask

    task automatic apply_write();
        case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_NUM_BUTTONS: cfg_buttons = pwdata[NUMBTN_W-1:0];
            REG_DEBOUNCE_MS: cfg_hold    = pwdata[DEBOUNCE_W-1:0];
            REG_EDGE_MODE:   cfg_edge    = pwdata[MASK_W-1:0];
            REG_PRESS_EN:    cfg_press   = pwdata[MASK_W-1:0];
            REG_RELEASE_EN:  cfg_release = pwdata[MASK_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_btn_event ev;
        if (!i_rst_n) begin
            cfg_buttons = '0;
            cfg_hold    = DEBOUNCE_RST;
            cfg_edge    = '0;
            cfg_press   = '0;
            cfg_release = '0;
            for (int i = 0; i < NBTN; i++) begin
                raw_seen[i]    = 1'b1;
                stable_seen[i] = 1'b1;
                raw_since[i]   = '0;
            end
            due_events.delete();
        end else begin
            // Older results leave first, so compare before adding new ones.
            if (i_evt_valid && i_evt_ready) begin
                compare_event();
            end
            if (i_smp_valid && i_smp_ready) begin
                if (debounce_sample(i_smp_button, i_smp_level, i_smp_now_ms, ev)) begin
                    due_events.push_back(ev);
                end
            end
            if (psel && penable && pwrite && pready) begin
                apply_write();
            end
        end
        o_pending = due_events.size();
    end

endmodule

// File: tb/multi_button_debouncer_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_button_debouncer_core_tb
// Drives time-stamped button samples and register writes into the debouncer
// and gives the verdict. A directed part walks through the corner cases,
// then random phases under several register settings press and release
// buttons with bounces, odd time jumps and random idling on both channels.
// Event items are checked by the checker instance next to the block.
// ============================================================================
module multi_button_debouncer_core_tb;
    import mbd_pkg::*;

    localparam int GAP_MAX         = 18;
    localparam int HOLD_OFF_CYCLES = 300;
    // Extra settling time after the last predicted event has come out.
    localparam int SETTLE_CYCLES   = 6;
    localparam int PHASE_ITEMS     = 100;
    localparam int CYCLE_LIMIT     = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mbd_sample_if smp_if ();
    mbd_event_if  evt_if ();

    int                fail_count;
    int                pending_count;
    int                cycle_count = 0;
    int                items_sent  = 0;
    bit                src_idle_on = 1'b0;
    bit                snk_idle_on = 1'b0;
    bit                hold_off_req = 1'b0;
    t_cfg              cur_cfg;
    logic [TIME_W-1:0] clock_ms;
    logic              aim_level [16];

    multi_button_debouncer_core #(
        .BUTTONS (16)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_event  (evt_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    multi_button_debouncer_core_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_smp_valid      (smp_if.valid),
        .i_smp_ready      (smp_if.ready),
        .i_smp_button     (smp_if.button),
        .i_smp_level      (smp_if.level),
        .i_smp_now_ms     (smp_if.now_ms),
        .i_evt_valid      (evt_if.valid),
        .i_evt_ready      (evt_if.ready),
        .i_evt_button_id  (evt_if.button_id),
        .i_evt_event_res  (evt_if.event_res),
        .i_evt_stable_out (evt_if.stable_out),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // A hung handshake must not keep the run alive forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Event receiver. Before each item it stalls for a random number of
    // cycles when idling is on. A hold-off request from the stimulus turns
    // the next stall into a long one, so the pipeline fills up and the
    // sample input has to back-pressure the sender.
    initial begin : event_sink
        int stall;
        evt_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = snk_idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                evt_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            evt_if.ready <= 1'b1;
            do @(posedge i_clk); while (!evt_if.valid);
        end
    end

    // Offers one sample and returns at the edge where it is taken. Valid is
    // left high so that a back-to-back item can follow without a gap; the
    // caller lowers it through settle() when a burst ends.
    task automatic offer_sample(input logic [BUTTON_W-1:0] b, input logic lvl,
                                input logic [TIME_W-1:0] t);
        int gap;
        gap = src_idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.button <= b;
        smp_if.level  <= lvl;
        smp_if.now_ms <= t;
        do @(posedge i_clk); while (!smp_if.ready);
        // Ignored samples do not count toward the run length.
        if ({1'b0, b} < cur_cfg.num_buttons) begin
            items_sent++;
        end
    endtask

    // Stops sending and waits until every predicted event has come out,
    // then waits SETTLE_CYCLES more for samples that produce nothing.
    task automatic settle();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle. psel stays high between back-to-back
    // writes; reconfigure() drops it after the last one.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Registers are only touched while the block is idle.
    task automatic reconfigure(input t_cfg c);
        settle();
        write_reg(REG_NUM_BUTTONS, DATA_W'(c.num_buttons));
        write_reg(REG_DEBOUNCE_MS, DATA_W'(c.debounce_ms));
        write_reg(REG_EDGE_MODE,   DATA_W'(c.edge_mode));
        write_reg(REG_PRESS_EN,    DATA_W'(c.press_en));
        write_reg(REG_RELEASE_EN,  DATA_W'(c.release_en));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_cfg = c;
    endtask

    // A well-formed press or release: a few bounces, the new level, then the
    // same level again after (usually) enough time to be accepted.
    task automatic debounced_sequence(input logic [BUTTON_W-1:0] b);
        int bounces;
        aim_level[b] = ~aim_level[b];
        bounces = $urandom_range(0, 3);
        repeat (bounces) begin
            offer_sample(b, 1'($urandom_range(0, 1)), clock_ms);
            clock_ms += $urandom_range(0, 2);
        end
        offer_sample(b, aim_level[b], clock_ms);
        if ($urandom_range(0, 4) != 0) begin
            clock_ms += cur_cfg.debounce_ms + $urandom_range(0, 3);
        end else begin
            clock_ms += $urandom_range(0, cur_cfg.debounce_ms);
        end
        offer_sample(b, aim_level[b], clock_ms);
    endtask

    // Noise: random level with a time jump anywhere, a step back, or a
    // small step forward.
    task automatic stray_sample(input logic [BUTTON_W-1:0] b);
        case ($urandom_range(0, 2))
            0:       clock_ms = $urandom();
            1:       clock_ms -= $urandom_range(1, 50);
            default: clock_ms += $urandom_range(0, 3);
        endcase
        offer_sample(b, 1'($urandom_range(0, 1)), clock_ms);
    endtask

    // Mostly well-formed sequences on buttons in use, some noise and a few
    // samples on any index. Optionally drains the block halfway through.
    task automatic random_phase(input int n_items, input bit pause_midway);
        int                  first;
        int                  span;
        logic [BUTTON_W-1:0] b;
        first = items_sent;
        span  = (cur_cfg.num_buttons > 16) ? 16 : int'(cur_cfg.num_buttons);
        while (items_sent - first < n_items) begin
            if (pause_midway && items_sent - first >= n_items / 2) begin
                settle();
                pause_midway = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                b = BUTTON_W'($urandom_range(0, 15));
            end else begin
                b = BUTTON_W'($urandom_range(0, span - 1));
            end
            if ($urandom_range(0, 4) == 0) begin
                stray_sample(b);
            end else begin
                debounced_sequence(b);
            end
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        smp_if.valid  <= 1'b0;
        smp_if.button <= '0;
        smp_if.level  <= 1'b1;
        smp_if.now_ms <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        clock_ms = '0;
        for (int i = 0; i < 16; i++) begin
            aim_level[i] = 1'b1;
        end
        cur_cfg = '{5'd0, DEBOUNCE_RST, 16'h0000, 16'h0000, 16'h0000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part ------------------------------------------------
        // Out of reset no button is in use, so these must be ignored.
        offer_sample(4'd3, 1'b0, 32'd0);
        offer_sample(4'd0, 1'b0, 32'hFFFF_FFFF);

        // Low eight buttons in edge mode, release events only on some.
        reconfigure('{5'd16, 16'd5, 16'h00FF, 16'hFFFF, 16'h0F0F});
        offer_sample(4'd0, 1'b0, 32'd100);          // new level, not held yet
        offer_sample(4'd0, 1'b0, 32'd105);          // held exactly: press
        offer_sample(4'd0, 1'b1, 32'd106);
        offer_sample(4'd0, 1'b1, 32'd111);          // release
        offer_sample(4'd15, 1'b0, 32'hFFFF_FFFE);
        offer_sample(4'd15, 1'b0, 32'd3);           // held across the wrap: change
        offer_sample(4'd1, 1'b0, 32'd1000);
        offer_sample(4'd1, 1'b0, 32'd999);          // time ran back: counts as held
        offer_sample(4'd2, 1'b0, 32'd200);          // bouncing contact
        offer_sample(4'd2, 1'b1, 32'd202);
        offer_sample(4'd2, 1'b0, 32'd204);
        offer_sample(4'd2, 1'b0, 32'd210);          // press after the last bounce
        offer_sample(4'd4, 1'b0, 32'd300);
        offer_sample(4'd4, 1'b0, 32'd305);          // press
        offer_sample(4'd4, 1'b1, 32'd306);
        offer_sample(4'd4, 1'b1, 32'd320);          // release disabled: silent

        // More buttons than exist, zero hold time, one change event disabled.
        reconfigure('{5'd20, 16'd0, 16'h0000, 16'h7FFF, 16'h0000});
        offer_sample(4'd9, 1'b0, 32'd0);            // accepted on first sight
        offer_sample(4'd15, 1'b1, 32'hFFFF_FFFF);   // level moves, no event

        // Longest hold time, only three buttons in use.
        reconfigure('{5'd3, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
        offer_sample(4'd3, 1'b0, 32'd0);            // out of use
        offer_sample(4'd2, 1'b1, 32'd10);
        offer_sample(4'd2, 1'b1, 32'd65544);        // one short of the hold
        offer_sample(4'd2, 1'b1, 32'd65545);        // release

        // ---- Random part --------------------------------------------------
        // Every button edge-triggered and fully enabled, both sides idling.
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        clock_ms = 32'd1000;
        reconfigure('{5'd16, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        random_phase(PHASE_ITEMS, 1'b0);

        // Zero hold and change events at full rate; the receiver holds off
        // for a long stretch while samples keep coming.
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        reconfigure('{5'd16, 16'd0, 16'h0000, 16'hFFFF, 16'h0000});
        hold_off_req = 1'b1;
        random_phase(PHASE_ITEMS, 1'b0);

        // Random setting; the sender pauses halfway until all events are out.
        src_idle_on = 1'b1;
        snk_idle_on = 1'b0;
        c.num_buttons = NUMBTN_W'($urandom_range(1, 16));
        c.debounce_ms = DEBOUNCE_W'($urandom_range(0, 20));
        c.edge_mode   = MASK_W'($urandom());
        c.press_en    = MASK_W'($urandom());
        c.release_en  = MASK_W'($urandom());
        reconfigure(c);
        random_phase(PHASE_ITEMS, 1'b1);

        // Largest register values: every index in use, longest hold.
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        c.num_buttons = 5'd31;
        c.debounce_ms = 16'hFFFF;
        c.edge_mode   = MASK_W'($urandom());
        c.press_en    = MASK_W'($urandom());
        c.release_en  = MASK_W'($urandom());
        reconfigure(c);
        random_phase(PHASE_ITEMS, 1'b0);

        // Short holds with the millisecond counter about to wrap.
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        clock_ms = 32'hFFFF_FF80;
        c.num_buttons = NUMBTN_W'($urandom_range(8, 16));
        c.debounce_ms = DEBOUNCE_W'($urandom_range(0, 7));
        c.edge_mode   = 16'hAAAA;
        c.press_en    = MASK_W'($urandom());
        c.release_en  = MASK_W'($urandom());
        reconfigure(c);
        random_phase(PHASE_ITEMS, 1'b0);

        // Nothing in use: every sample is dropped.
        reconfigure('{5'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        repeat (12) stray_sample(BUTTON_W'($urandom_range(0, 15)));

        // Back to a busy setting to see the state survived the quiet phase.
        reconfigure('{5'd16, 16'd2, 16'h0F0F, 16'hFFFF, 16'hFFFF});
        random_phase(PHASE_ITEMS, 1'b0);

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
